// ===== design/pwmes_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmes_pkg
// Shared types and constants for the eight-channel pwm event scheduler.
// ----------------------------------------------------------------------------
package pwmes_pkg;

  // pin and duty geometry
  localparam int NUM_PINS = 8;
  localparam int DUTY_W   = 8;
  localparam int TIME_W   = 8;

  // event kinds carried on the input tuser
  localparam logic CMD_PERIOD  = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  // configuration register indexes
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_DUTY   = 1'b1;

  // next compare time when no later duty exists
  localparam logic [TIME_W-1:0] NO_COMPARE = 8'hff;

  // output word layout
  localparam int OUT_TDATA_W = 24;

  typedef logic [NUM_PINS-1:0]        pin_vec_t;
  typedef logic [NUM_PINS*DUTY_W-1:0] duty_vec_t;

  // one timer event
  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] now;
  } event_t;

  // one result word
  typedef struct packed {
    logic              has_next;
    logic [TIME_W-1:0] next_compare;
    pin_vec_t          pin_levels;
  } result_t;

endpackage

// ===== design/pwmes_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pwmes_cfg_regs
// Enable mask and packed duty registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pwmes_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [63:0]         cfg_wdata,
  output pwmes_pkg::pin_vec_t  enable_mask,
  output pwmes_pkg::duty_vec_t duty_values
);
  import pwmes_pkg::*;

  pin_vec_t  enable_r;
  duty_vec_t duty_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      duty_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENABLE: enable_r <= cfg_wdata[NUM_PINS-1:0];
        REG_DUTY:   duty_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign enable_mask = enable_r;
  assign duty_values = duty_r;

endmodule

// ===== design/pwmes_in_stage.sv =====
// ----------------------------------------------------------------------------
// pwmes_in_stage
// Input register for one timer event, with slave-side handshake.
// ----------------------------------------------------------------------------
module pwmes_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pwmes_pkg::event_t in_event,
  input  logic              take,      // downstream accepts the held word
  output logic              evt_valid,
  output pwmes_pkg::event_t evt
);
  import pwmes_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  event_t evt_r;

  // free when empty or when the held word moves on this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r <= in_event;
    end
  end

  assign evt_valid = valid_r;
  assign evt       = evt_r;

endmodule

// ===== design/pwmes_core.sv =====
// ----------------------------------------------------------------------------
// pwmes_core
// Pin register update and next compare search for one event.
// ----------------------------------------------------------------------------
module pwmes_core #(
  parameter logic [7:0] LIVE_MASK = 8'hff
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,   // event retires into the output register
  input  pwmes_pkg::event_t    evt,
  input  pwmes_pkg::pin_vec_t  enable_mask,
  input  pwmes_pkg::duty_vec_t duty_values,
  output pwmes_pkg::result_t   result
);
  import pwmes_pkg::*;

  pin_vec_t          pin_r;
  pin_vec_t          pin_nxt;
  pin_vec_t          live;
  pin_vec_t          raise;
  pin_vec_t          keep;
  logic [TIME_W-1:0] next_min;
  logic              found;

  assign live = enable_mask & LIVE_MASK;

  // per-channel compare and running minimum over enabled duties
  always_comb begin
    logic [DUTY_W-1:0] d;
    d        = '0;
    raise    = '0;
    keep     = '1;
    next_min = NO_COMPARE;
    found    = 1'b0;
    for (int ch = 0; ch < NUM_PINS; ch++) begin
      d = duty_values[ch*DUTY_W +: DUTY_W];
      if (live[ch]) begin
        if (evt.cmd == CMD_PERIOD) begin
          if (d != '0) begin
            raise[ch] = 1'b1;
            found     = 1'b1;
            if (d < next_min) next_min = d;
          end
        end else if (d <= evt.now) begin
          keep[ch] = 1'b0;
        end else begin
          found = 1'b1;
          if (d < next_min) next_min = d;
        end
      end
    end
  end

  // new pin levels
  always_comb begin
    if (evt.cmd == CMD_PERIOD) begin
      pin_nxt = (pin_r & ~live) | raise;
    end else begin
      pin_nxt = pin_r & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
    end else if (advance) begin
      pin_r <= pin_nxt;
    end
  end

  assign result.pin_levels   = pin_nxt;
  assign result.next_compare = next_min;
  assign result.has_next     = found;

endmodule

// ===== design/pwmes_out_stage.sv =====
// ----------------------------------------------------------------------------
// pwmes_out_stage
// Result register with master-side handshake.
// ----------------------------------------------------------------------------
module pwmes_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  pwmes_pkg::result_t                  result,
  output logic                                free,  // register can take a word now
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pwmes_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pwmes_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res_r};

endmodule

// ===== design/eight_channel_pwm_event_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// eight_channel_pwm_event_scheduler_unit
// Event-driven pwm output driver for up to eight channels.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one timer event per word; in_tuser is the kind (0 period start,
//           1 compare match), in_tdata carries the current timer count.
//   out_* : one result word per event: pin levels after the event, the next
//           compare time to program (0xff when none) and a found flag.
//   cfg_* : index 0 is the enable mask, index 1 the eight packed duties;
//           write only while no event is in flight.
// An accepted event is held in the input register, then the pin update and
// an eight-way minimum search feed the result register. One event is taken
// every cycle while the result side keeps up. When out_tready is low the
// result holds, one more event waits in the input register, and in_tready
// then drops.
// Reset clears the pin register, both configuration registers and all valid
// flags; no clearing pass is needed, events are taken right after reset.
// Channels at or above CHANNELS count as disabled.
// ----------------------------------------------------------------------------
module eight_channel_pwm_event_scheduler_unit #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input events
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] now
  input  logic        in_tuser,   // [0] cmd
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] pin_levels, [15:8] next_compare,
                                  // [16] has_next, [23:17] zero
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_wdata
);
  import pwmes_pkg::*;

  localparam logic [NUM_PINS-1:0] LIVE_MASK = NUM_PINS'((1 << CHANNELS) - 1);

  pin_vec_t  enable_mask;
  duty_vec_t duty_values;
  event_t    in_event;
  event_t    evt;
  logic      evt_valid;
  logic      out_free;
  logic      advance;
  result_t   result;

  assign in_event.cmd = in_tuser;
  assign in_event.now = in_tdata;

  // event retires when held and the result register can take it
  assign advance = evt_valid && out_free;

  pwmes_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .enable_mask (enable_mask),
    .duty_values (duty_values)
  );

  pwmes_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_event  (in_event),
    .take      (advance),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  pwmes_core #(
    .LIVE_MASK (LIVE_MASK)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .evt         (evt),
    .enable_mask (enable_mask),
    .duty_values (duty_values),
    .result      (result)
  );

  pwmes_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/pwmes_checker.sv =====
// ----------------------------------------------------------------------------
// pwmes_checker
// Port-level checks for the pwm event scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pwmes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no result word right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // without a found duty the next compare time is the idle value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:8] == 8'hff)
    else $error("next compare not idle when nothing found");

  // a found compare time is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:8] != 8'h00)
    else $error("found compare time is zero");

  // an accepted event with the output empty shows a result word after passing the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result word missing after accepted event");

endmodule

bind eight_channel_pwm_event_scheduler_unit pwmes_checker u_pwmes_checker (.*);
